/* rtl/wgas_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, state encoding and control structs for the wind gust and
// average speed core. No dependencies.

package wgas_pkg;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int WIN_W   = 22;
    localparam int PCNT_W  = 20;
    localparam int PEAK_W  = 9;
    localparam int SPEED_W = 32;
    localparam int FRAC_W  = 16;

    // Speed scale: 1.319 m/s per rev/s, kept as 1319 over milliseconds
    localparam int              SPEED_NUM_W = 11;
    localparam logic [10:0]     SPEED_NUM   = 11'd1319;
    localparam int              PROD_W      = SPEED_NUM_W + PCNT_W;
    localparam int              NUM_W       = PROD_W + FRAC_W;

    // Gust span: 3 s in microseconds for the scan, in milliseconds for the gust scale
    localparam logic [TIME_W-1:0] GUST_SPAN_US = 32'd3000000;
    localparam int                GUST_SPAN_MS = 3000;

    localparam logic [WIN_W-1:0] WIN_RESET = 22'd60000;

    // Parameter defaults
    localparam int BUFFER_DEPTH_DEF   = 256;
    localparam int PULSES_PER_REV_DEF = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_START_AVG,
        ST_DIV_AVG,
        ST_GUST_PREP,
        ST_GUST_SAVE,
        ST_EMIT
    } wgas_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;       // latch the accepted item
        logic store;         // write its timestamp into the buffer
        logic advance;       // move the start pointer one entry
        logic peak_update;   // fold newest - start into the peak
        logic div_start;     // load the divider with the average operands
        logic gust_prep;     // latch the gust partial products
        logic save_avg;
        logic save_gust;
        logic emit;          // load the output register, clear window state
    } wgas_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic advance_ok;
        logic closing;
        logic div_done;
        logic out_free;
    } wgas_status_t;

endpackage

/* rtl/wgas_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pulse input, result output, window config.
// Depends on wgas_pkg.

interface wgas_in_if import wgas_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] pulse_time_us;
    logic              has_pulse;
    logic [PCNT_W-1:0] pulse_count;
    logic              window_end;

    modport source (output valid, pulse_time_us, has_pulse, pulse_count, window_end,
                    input ready);
    modport sink   (input valid, pulse_time_us, has_pulse, pulse_count, window_end,
                    output ready);
endinterface

interface wgas_out_if import wgas_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] average_speed_q16;
    logic [SPEED_W-1:0] gust_speed_q16;
    logic [PEAK_W-1:0]  peak_periods;

    modport source (output valid, average_speed_q16, gust_speed_q16, peak_periods,
                    input ready);
    modport sink   (input valid, average_speed_q16, gust_speed_q16, peak_periods,
                    output ready);
endinterface

interface wgas_cfg_if import wgas_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [WIN_W-1:0] sample_window_ms;

    modport source (output valid, sample_window_ms, input ready);
    modport sink   (input valid, sample_window_ms, output ready);
endinterface

/* rtl/wgas_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.

module wgas_div #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 23
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num_in,
    input  logic [DEN_W-1:0] den_in,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  den_reg;

    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    diff;
    logic              fits;

    // One shift-subtract step
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[NUM_W-1]};
        diff   = rem_sh - {1'b0, den_reg};
        fits   = (rem_sh >= {1'b0, den_reg});
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num_in;
            den_reg <= den_in;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/wgas_dp.sv */
`timescale 1ns / 1ps
// Datapath: timestamp buffer, start pointer scan, peak tracking, speed
// arithmetic and the output register. Depends on wgas_pkg and wgas_div.

module wgas_dp import wgas_pkg::*; #(
    parameter int BUFFER_DEPTH   = BUFFER_DEPTH_DEF,
    parameter int PULSES_PER_REV = PULSES_PER_REV_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // window length register
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [WIN_W-1:0]   cfg_data,
    // accepted item fields
    input  logic [TIME_W-1:0]  in_time,
    input  logic [PCNT_W-1:0]  in_count,
    input  logic               in_window_end,
    // control
    input  wgas_cmd_t          cmd,
    output wgas_status_t       status,
    // result
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SPEED_W-1:0] out_avg,
    output logic [SPEED_W-1:0] out_gust,
    output logic [PEAK_W-1:0]  out_peak
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int PPR_W  = $clog2(PULSES_PER_REV + 1);
    localparam int DEN_W  = WIN_W + PPR_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BUFFER_DEPTH);

    // Gust = peak * NUM / DEN, split as peak * QUO + floor(peak * REM / DEN);
    // the second term uses a reciprocal that is exact for every peak * REM
    localparam longint unsigned GUST_NUM = 64'(SPEED_NUM) << FRAC_W;
    localparam longint unsigned GUST_DEN = 64'(GUST_SPAN_MS * PULSES_PER_REV);
    localparam longint unsigned GUST_QUO = GUST_NUM / GUST_DEN;
    localparam longint unsigned GUST_REM = GUST_NUM % GUST_DEN;
    localparam int              GUST_L   = $clog2(GUST_DEN);
    localparam int              GX_W     = ADDR_W + GUST_L;
    localparam int              GUST_S   = GX_W + GUST_L;
    localparam longint unsigned GUST_M   = ((64'd1 << GUST_S) + GUST_DEN - 64'd1) / GUST_DEN;
    localparam int              GP_W     = 2 * GX_W + 1;

    function automatic logic [SPEED_W-1:0] sat_speed(input logic [NUM_W-1:0] q);
        logic [SPEED_W-1:0] r;
        begin
            r = (|q[NUM_W-1:SPEED_W]) ? '1 : q[SPEED_W-1:0];
            return r;
        end
    endfunction

    logic [WIN_W-1:0]   win_reg;
    logic [TIME_W-1:0]  t_reg;
    logic [PCNT_W-1:0]  count_reg;
    logic               end_reg;
    logic [CNT_W-1:0]   stored_reg,  stored_next;
    logic [ADDR_W-1:0]  start_reg,   start_next;
    logic [ADDR_W-1:0]  peak_reg,    peak_next;
    logic [ADDR_W-1:0]  newest_reg;
    logic [SPEED_W-1:0] avg_reg;
    logic [SPEED_W-1:0] gust_reg;
    logic               out_valid_reg;
    logic [SPEED_W-1:0] out_avg_reg;
    logic [SPEED_W-1:0] out_gust_reg;
    logic [PEAK_W-1:0]  out_peak_reg;
    logic [GX_W-1:0]    gust_x_reg;
    logic [NUM_W-1:0]   gust_base_reg;

    logic [TIME_W-1:0]  mem [BUFFER_DEPTH];
    logic [TIME_W-1:0]  rd_data_reg;

    logic [ADDR_W-1:0]  periods;
    logic [TIME_W-1:0]  span;
    logic [PROD_W-1:0]  product;
    logic [DEN_W-1:0]   den;
    logic               div_done;
    logic [NUM_W-1:0]   div_quo;
    logic [SPEED_W-1:0] quo_sat;
    logic               win_zero;
    logic [GP_W-1:0]    gust_prod;
    logic [NUM_W-1:0]   gust_raw;
    logic [SPEED_W-1:0] gust_sat;

    // Window register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= WIN_RESET;
        else if (cfg_valid)
            win_reg <= cfg_data;
    end

    // Pointer and peak next values
    assign periods = newest_reg - start_reg;

    always_comb
    begin
        stored_next = stored_reg;
        start_next  = start_reg;
        peak_next   = peak_reg;
        if (cmd.store)
            stored_next = stored_reg + CNT_W'(1);
        if (cmd.advance)
            start_next = start_reg + ADDR_W'(1);
        if (cmd.peak_update && (periods > peak_reg))
            peak_next = periods;
        if (cmd.emit)
        begin
            stored_next = '0;
            start_next  = '0;
            peak_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg <= '0;
            start_reg  <= '0;
            peak_reg   <= '0;
            end_reg    <= 1'b0;
        end
        else
        begin
            stored_reg <= stored_next;
            start_reg  <= start_next;
            peak_reg   <= peak_next;
            if (cmd.capture)
                end_reg <= in_window_end;
        end
    end

    // Item fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            t_reg     <= in_time;
            count_reg <= in_count;
        end
        if (cmd.store)
            newest_reg <= stored_reg[ADDR_W-1:0];
    end

    // Timestamp buffer; read port follows the start pointer
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            mem[stored_reg[ADDR_W-1:0]] <= in_time;
        rd_data_reg <= mem[start_next];
    end

    assign span = t_reg - rd_data_reg;

    // Average divide by the window length
    assign product = PROD_W'(SPEED_NUM) * PROD_W'(count_reg);
    assign den     = DEN_W'(win_reg) * DEN_W'(PULSES_PER_REV);

    wgas_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .num_in ({product, {FRAC_W{1'b0}}}),
        .den_in (den),
        .done   (div_done),
        .quo    (div_quo)
    );

    assign win_zero = (win_reg == '0);
    assign quo_sat  = win_zero ? '0 : sat_speed(div_quo);

    // Gust partial products, then the reciprocal step
    always_ff @(posedge clk)
    begin
        if (cmd.gust_prep)
        begin
            gust_x_reg    <= GX_W'(peak_reg) * GX_W'(GUST_REM);
            gust_base_reg <= NUM_W'(peak_reg) * NUM_W'(GUST_QUO);
        end
    end

    assign gust_prod = GP_W'(gust_x_reg) * GP_W'(GUST_M);
    assign gust_raw  = gust_base_reg + NUM_W'(gust_prod[GP_W-1:GUST_S]);
    assign gust_sat  = win_zero ? '0 : sat_speed(gust_raw);

    // Speed results; gust is never below the average
    always_ff @(posedge clk)
    begin
        if (cmd.save_avg)
            avg_reg <= quo_sat;
        if (cmd.save_gust)
            gust_reg <= (gust_sat < avg_reg) ? avg_reg : gust_sat;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_avg_reg  <= avg_reg;
            out_gust_reg <= gust_reg;
            out_peak_reg <= PEAK_W'(peak_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_avg   = out_avg_reg;
    assign out_gust  = out_gust_reg;
    assign out_peak  = out_peak_reg;

    // Status
    always_comb
    begin
        status.full       = (stored_reg == FULL_CNT);
        status.advance_ok = (start_reg < newest_reg) && (span > GUST_SPAN_US);
        status.closing    = end_reg;
        status.div_done   = div_done;
        status.out_free   = !out_valid_reg || out_ready;
    end

endmodule

/* rtl/wgas_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences item capture, the start pointer scan, the average
// divide, the gust multiply and the result load. Depends on wgas_pkg.

module wgas_ctrl import wgas_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         in_has_pulse,
    input  logic         in_window_end,
    input  wgas_status_t status,
    output wgas_cmd_t    cmd
);

    wgas_state_t state_reg, state_next;
    logic        accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_has_pulse && !status.full)
                        state_next = ST_SCAN;
                    else if (in_window_end)
                        state_next = ST_START_AVG;
                end
            end
            ST_SCAN:
            begin
                if (!status.advance_ok)
                    state_next = status.closing ? ST_START_AVG : ST_IDLE;
            end
            ST_START_AVG:  state_next = ST_DIV_AVG;
            ST_DIV_AVG:
            begin
                if (status.div_done)
                    state_next = ST_GUST_PREP;
            end
            ST_GUST_PREP:  state_next = ST_GUST_SAVE;
            ST_GUST_SAVE:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = accept;
                cmd.store   = accept && in_has_pulse && !status.full;
            end
            ST_SCAN:
            begin
                cmd.advance     = status.advance_ok;
                cmd.peak_update = !status.advance_ok;
            end
            ST_START_AVG:
            begin
                cmd.div_start = 1'b1;
            end
            ST_DIV_AVG:
            begin
                cmd.save_avg = status.div_done;
            end
            ST_GUST_PREP:
            begin
                cmd.gust_prep = 1'b1;
            end
            ST_GUST_SAVE:
            begin
                cmd.save_gust = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/wind_gust_and_average_speed_core.sv */
`timescale 1ns / 1ps
// Top level of the wind gust and average speed core.
// Depends on wgas_pkg, wgas_if, wgas_ctrl, wgas_dp and wgas_div.

// Takes one pulse timestamp item at a time. An item without a pulse, or
// with a pulse that arrives once BUFFER_DEPTH timestamps are held, is not
// stored or scanned; a stored pulse is followed by a scan of the 3 s start
// pointer, which reads one buffer entry per cycle through the single read
// port. The closing item then runs one bit-serial divide of 47 quotient
// bits for the average and a reciprocal multiply on registered partial
// products for the gust before the result is loaded into the output
// register; the next window's items are taken once the result is loaded, even
// while it still waits to be taken. sample_window_ms may be written at any time
// the core is idle; speeds are Q16.16 m/s, truncated and saturated.

module wind_gust_and_average_speed_core import wgas_pkg::*; #(
    parameter int BUFFER_DEPTH   = BUFFER_DEPTH_DEF,
    parameter int PULSES_PER_REV = PULSES_PER_REV_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    wgas_cfg_if.sink    cfg,
    wgas_in_if.sink     pulse_in,
    wgas_out_if.source  result_out
);

    wgas_cmd_t    cmd;
    wgas_status_t status;

    wgas_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (pulse_in.valid),
        .in_ready      (pulse_in.ready),
        .in_has_pulse  (pulse_in.has_pulse),
        .in_window_end (pulse_in.window_end),
        .status        (status),
        .cmd           (cmd)
    );

    wgas_dp #(
        .BUFFER_DEPTH   (BUFFER_DEPTH),
        .PULSES_PER_REV (PULSES_PER_REV)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg.valid),
        .cfg_ready     (cfg.ready),
        .cfg_data      (cfg.sample_window_ms),
        .in_time       (pulse_in.pulse_time_us),
        .in_count      (pulse_in.pulse_count),
        .in_window_end (pulse_in.window_end),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (result_out.valid),
        .out_ready     (result_out.ready),
        .out_avg       (result_out.average_speed_q16),
        .out_gust      (result_out.gust_speed_q16),
        .out_peak      (result_out.peak_periods)
    );

    // Result is loaded only into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result loaded over an untaken result");

    // Pointer steps only while the span still exceeds 3 s
    a_advance_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> status.advance_ok)
        else $error("start pointer moved without cause");

    // A new result appears only after a load command
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_out.valid) |-> $past(cmd.emit))
        else $error("result valid without a load");

    // Capture, scan, divide and load never overlap
    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.advance, cmd.div_start, cmd.emit}))
        else $error("overlapping control phases");

endmodule
